// File: src/nrl_pkg.sv
// Shared widths, field layout and sequencer state type for the nearest region lookup.
// No dependencies; imported by the top level.
package nrl_pkg;

    localparam int ENTRY_W    = 4;   // table slot field of a write beat
    localparam int RADIUS_W   = 15;  // detection radius field
    localparam int CFG_W      = 5;   // regions_in_use register
    localparam int REGION_W   = 4;   // matched index in the result
    localparam int OUT_TDATA_W = 8;  // result tdata, padded to a byte

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } nrl_state_t;

endpackage

// File: src/nrl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the region table of the lookup unit.
module nrl_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/nearest_region_lookup_unit.sv
// Nearest region lookup: region table, scan sequencer and shared distance unit.
// Depends on nrl_pkg and nrl_ram.
//
// Usage
//   cfg channel: one beat on cfg_valid writes regions_in_use; cfg_ready is always high.
//   s_axis: tuser[0] is the op. A write beat (op 0) stores centre and radius in the
//   slot given by entry_index and returns nothing. A query beat
//   (op 1) gives a point and returns one result beat on m_axis.
//   m_axis: tuser[0] is found, tdata[3:0] the matched region index (0 if not found).
// Timing
//   A query scans N = min(regions_in_use, MAX_REGIONS) entries, one per cycle, through
//   the single RAM read port and a four-stage distance unit (abs difference, square,
//   sum, min/radius update). The result goes to the output register when the sequencer
//   leaves the finish state; s_axis_tready is low for the whole query, so the next
//   beat is taken only once the sequencer is back in idle.
// Reset and stalls
//   rst_n clears regions_in_use to 0 and the sequencer to idle; the table contents
//   are undefined until written. A result held by a stalled receiver stays in the
//   output register; the next beat is accepted meanwhile, and a following query holds
//   its result in the finish state until the output register frees up.
module nearest_region_lookup_unit
    import nrl_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_BITS  = 16,
    localparam int IN_BITS = ENTRY_W + 3 * COORD_BITS + RADIUS_W,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,       // regions_in_use

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, point_x, point_y, point_z, radius, zero padding
    input  logic [IN_W-1:0]        s_axis_tdata,
    input  logic [0:0]             s_axis_tuser,   // op

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // region_index, zero padding
    output logic [0:0]             m_axis_tuser    // found
);

    localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int X_LSB   = ENTRY_W;
    localparam int Y_LSB   = X_LSB + COORD_BITS;
    localparam int Z_LSB   = Y_LSB + COORD_BITS;
    localparam int R_LSB   = Z_LSB + COORD_BITS;
    localparam int ENT_W   = 3 * COORD_BITS + RADIUS_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int R2_W    = 2 * RADIUS_W;
    localparam int D2_W    = (SQ_W + 2 > R2_W) ? SQ_W + 2 : R2_W;

    // Input field split
    logic [ENTRY_W-1:0]    in_slot;
    logic [COORD_BITS-1:0] in_x, in_y, in_z;
    logic [RADIUS_W-1:0]   in_radius;
    logic                  in_op;
    logic                  in_beat;

    assign in_slot   = s_axis_tdata[ENTRY_W-1:0];
    assign in_x      = s_axis_tdata[X_LSB +: COORD_BITS];
    assign in_y      = s_axis_tdata[Y_LSB +: COORD_BITS];
    assign in_z      = s_axis_tdata[Z_LSB +: COORD_BITS];
    assign in_radius = s_axis_tdata[R_LSB +: RADIUS_W];
    assign in_op     = s_axis_tuser[0];

    // Control state
    nrl_state_t            state_reg, state_next;
    logic [CFG_W-1:0]      count_reg;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                  v0_reg, v1_reg, v2_reg, v3_reg;
    logic                  have_min_reg, have_min_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload
    logic [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]      idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [DIFF_W-1:0]     ad_x_reg, ad_y_reg, ad_z_reg;
    logic [RADIUS_W-1:0]   rad1_reg;
    logic [SQ_W-1:0]       sq_x_reg, sq_y_reg, sq_z_reg;
    logic [R2_W-1:0]       r2_reg;
    logic [D2_W-1:0]       d2_reg, r2_3_reg, best_reg, best_next;
    logic [IDX_W-1:0]      match_reg, match_next;
    logic                  out_found_reg;
    logic [IDX_W-1:0]      out_index_reg;

    // Handshakes
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Scan length saturates at the table size
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] count_sat;

    assign count_ext = CMP_W'(count_reg);
    assign count_sat = (count_ext > CMP_W'(MAX_REGIONS)) ? CMP_W'(MAX_REGIONS) : count_ext;

    // Table RAM: written from idle, read while scanning
    logic             issue;
    logic             slot_ok;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    assign issue     = (state_reg == ST_SCAN) && (issue_cnt_reg != scan_cnt_reg);
    assign slot_ok   = (32'(in_slot) < MAX_REGIONS);
    assign ram_we    = in_beat && (in_op == OP_WRITE) && slot_ok;
    assign ram_addr  = (state_reg == ST_IDLE) ? IDX_W'(in_slot) : issue_cnt_reg[IDX_W-1:0];
    assign ram_wdata = {in_radius, in_z, in_y, in_x};

    nrl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Distance unit, stage 1: absolute coordinate differences
    logic [COORD_BITS-1:0] cx, cy, cz;
    logic [DIFF_W-1:0]     dx, dy, dz;
    logic [DIFF_W-1:0]     adx, ady, adz;
    logic [DIFF_W-1:0]     one_d;

    assign cx    = ram_rdata[0 +: COORD_BITS];
    assign cy    = ram_rdata[COORD_BITS +: COORD_BITS];
    assign cz    = ram_rdata[2 * COORD_BITS +: COORD_BITS];
    assign one_d = {{(DIFF_W - 1){1'b0}}, 1'b1};
    assign dx    = {cx[COORD_BITS-1], cx} - {px_reg[COORD_BITS-1], px_reg};
    assign dy    = {cy[COORD_BITS-1], cy} - {py_reg[COORD_BITS-1], py_reg};
    assign dz    = {cz[COORD_BITS-1], cz} - {pz_reg[COORD_BITS-1], pz_reg};
    assign adx   = dx[DIFF_W-1] ? (~dx + one_d) : dx;
    assign ady   = dy[DIFF_W-1] ? (~dy + one_d) : dy;
    assign adz   = dz[DIFF_W-1] ? (~dz + one_d) : dz;

    // Stage 4: running strict minimum and radius gate
    logic new_min;

    assign new_min = v3_reg && (!have_min_reg || (d2_reg < best_reg));

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        issue_cnt_next = issue_cnt_reg;
        have_min_next  = have_min_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (new_min)
        begin
            have_min_next = 1'b1;
            best_next     = d2_reg;
            if (d2_reg <= r2_3_reg)
            begin
                found_next = 1'b1;
                match_next = idx3_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (in_op == OP_QUERY))
                begin
                    scan_cnt_next  = count_sat[CNT_W-1:0];
                    issue_cnt_next = '0;
                    have_min_next  = 1'b0;
                    found_next     = 1'b0;
                    match_next     = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                else if (!v0_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            issue_cnt_reg <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            have_min_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            v0_reg        <= issue;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            have_min_reg  <= have_min_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Datapath registers: no reset, qualified by the stage valid bits
    always_ff @(posedge clk)
    begin
        if (in_beat && (in_op == OP_QUERY))
        begin
            px_reg <= in_x;
            py_reg <= in_y;
            pz_reg <= in_z;
        end
        idx0_reg <= issue_cnt_reg[IDX_W-1:0];
        // stage 1
        ad_x_reg <= adx;
        ad_y_reg <= ady;
        ad_z_reg <= adz;
        rad1_reg <= ram_rdata[3 * COORD_BITS +: RADIUS_W];
        idx1_reg <= idx0_reg;
        // stage 2
        sq_x_reg <= SQ_W'(ad_x_reg) * SQ_W'(ad_x_reg);
        sq_y_reg <= SQ_W'(ad_y_reg) * SQ_W'(ad_y_reg);
        sq_z_reg <= SQ_W'(ad_z_reg) * SQ_W'(ad_z_reg);
        r2_reg   <= R2_W'(rad1_reg) * R2_W'(rad1_reg);
        idx2_reg <= idx1_reg;
        // stage 3
        d2_reg   <= D2_W'(sq_x_reg) + D2_W'(sq_y_reg) + D2_W'(sq_z_reg);
        r2_3_reg <= D2_W'(r2_reg);
        idx3_reg <= idx2_reg;
        // stage 4
        best_reg  <= best_next;
        match_reg <= match_next;
        if ((state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready))
        begin
            out_found_reg <= found_reg;
            out_index_reg <= match_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - REGION_W){1'b0}}, REGION_W'(out_index_reg)};

    // Checks
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg || v3_reg) |-> (state_reg == ST_SCAN))
        else $error("distance pipeline busy outside a scan");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= scan_cnt_reg))
        else $error("issue counter ran past the scan length");

    a_found_has_min: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> have_min_reg)
        else $error("match recorded without a running minimum");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

endmodule
